FILE: src/csma_pkg.sv
// ============================================================================
// csma_pkg - shared types and constants for the CSMA backoff channel arbiter
// Register indexes, result event codes, divider request bundle and the
// fixed field widths used by the arbiter and its remainder unit.
// ============================================================================
package csma_pkg;

    // Defaults and fixed limits
    localparam int NODES_DEFAULT  = 8;
    localparam int RANGE_ENTRIES  = 4;
    localparam int RANGE_REGS     = 4;
    localparam int RANGE_LIMIT    = (RANGE_ENTRIES < RANGE_REGS) ? RANGE_ENTRIES : RANGE_REGS;
    localparam int MAX_ACTIVE     = 15;

    // Field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ACTIVE_W   = 4;
    localparam int LEN_W      = 16;
    localparam int ATT_CFG_W  = 3;
    localparam int RANGE_W    = 16;
    localparam int BACKOFF_W  = 16;
    localparam int ATTEMPT_W  = 2;
    localparam int TICK_W     = 32;
    localparam int BUSY_W     = 32;
    localparam int NODE_ID_W  = 3;
    localparam int COLL_W     = 4;

    // Remainder unit widths: id + t + k needs one bit above the tick counter
    localparam int DIV_DVD_W = 33;
    localparam int DIV_DSR_W = 16;

    // Register reset values
    localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET  = 4'd8;
    localparam logic [LEN_W-1:0]     LEN_RESET     = 16'd20;
    localparam logic [ATT_CFG_W-1:0] ATT_RESET     = 3'd4;
    localparam int                   RANGE0_RESET  = 8;
    localparam logic [RANGE_W-1:0]   RANGE1_RESET  = 16'd16;
    localparam logic [RANGE_W-1:0]   RANGE2_RESET  = 16'd32;
    localparam logic [RANGE_W-1:0]   RANGE3_RESET  = 16'd64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_NODES = 3'd0,
        REG_PACKET_LEN   = 3'd1,
        REG_MAX_ATTEMPTS = 3'd2,
        REG_RANGE_0      = 3'd3,
        REG_RANGE_1      = 3'd4,
        REG_RANGE_2      = 3'd5,
        REG_RANGE_3      = 3'd6
    } cfg_reg_t;

    // Result event codes
    typedef enum logic [1:0] {
        EV_IDLE  = 2'd0,
        EV_START = 2'd1,
        EV_CONT  = 2'd2,
        EV_COLL  = 2'd3
    } event_t;

    // Request into the shared remainder unit
    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DSR_W-1:0] divisor;
    } div_req_t;

endpackage

FILE: src/csma_backoff_channel_arbiter.sv
// ============================================================================
// csma_backoff_channel_arbiter - shared channel with deterministic backoff
// Each request is one time tick. A small sequencer scans the node backoffs one
// node a cycle, pausing while its one remainder unit computes each new backoff.
// ============================================================================
// Per request: a tick with a packet in flight goes straight to the result; a countdown
// tick scans all n active nodes; a transmit start then waits for one remainder; a
// collision rescans and waits for one remainder per colliding node; a restart first
// reloads each stored node (at most 15) through the 33-step remainder unit. One request
// is in work at a time; in_ready returns in the same cycle as out_valid rises.
// Reset: asynchronous, active low; registers to defaults, backoff i to i mod 8.
module csma_backoff_channel_arbiter
    import csma_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tick requests
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  restart,
    // results
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            event_res,
    output logic [NODE_ID_W-1:0]  node_id,
    output logic [COLL_W-1:0]     colliders,
    output logic [BUSY_W-1:0]     busy_total,
    output logic [TICK_W-1:0]     tick_index
);

    // Only the first fifteen nodes can ever contend
    localparam int NODE_CAP = (NODES < MAX_ACTIVE) ? NODES : MAX_ACTIVE;
    localparam int IDX_W    = $clog2(NODE_CAP);
    localparam int CNT_W    = $clog2(NODE_CAP + 1);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_INIT      = 9'b000000010,
        S_INIT_WAIT = 9'b000000100,
        S_TICK      = 9'b000001000,
        S_SCAN      = 9'b000010000,
        S_SEND_WAIT = 9'b000100000,
        S_COLL      = 9'b001000000,
        S_COLL_WAIT = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration
    logic [ACTIVE_W-1:0]  active_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [ATT_CFG_W-1:0] max_att_reg;
    logic [RANGE_W-1:0]   range_reg [RANGE_REGS];

    // Node and channel state
    logic [BACKOFF_W-1:0] backoff_reg [NODE_CAP];
    logic [ATTEMPT_W-1:0] attempt_reg [NODE_CAP];
    logic [TICK_W-1:0]    tick_reg;
    logic [LEN_W-1:0]     busy_rem_reg;
    logic [BUSY_W-1:0]    busy_sum_reg;
    logic [NODE_ID_W-1:0] sender_reg;

    // Sequencer
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     last_reg;
    logic [COLL_W-1:0]    zeros_reg;
    logic [ATTEMPT_W-1:0] att_new_reg;

    // Result under construction and result register
    event_t               res_event_reg;
    logic [NODE_ID_W-1:0] res_node_reg;
    logic [COLL_W-1:0]    res_coll_reg;
    logic                 out_valid_reg;
    event_t               out_event_reg;
    logic [NODE_ID_W-1:0] out_node_reg;
    logic [COLL_W-1:0]    out_coll_reg;
    logic [BUSY_W-1:0]    out_busy_reg;
    logic [TICK_W-1:0]    out_tick_reg;

    // Derived values
    logic [CNT_W-1:0]     n_eff;
    logic [ACTIVE_W-1:0]  n_wide;
    logic [LEN_W-1:0]     len_eff;
    logic [ATT_CFG_W-1:0] lim_eff;
    logic                 idx_valid;
    logic [BACKOFF_W-1:0] cur_backoff;
    logic [ATTEMPT_W-1:0] cur_attempt;
    logic                 cur_zero;
    logic [ATT_CFG_W-1:0] att_inc;
    logic [ATTEMPT_W-1:0] att_wrap;
    logic [RANGE_W-1:0]   mod0;
    logic [RANGE_W-1:0]   mod_sel;
    logic [BUSY_W-1:0]    busy_inc;
    logic [ACTIVE_W-1:0]  last_wide;
    logic [NODE_ID_W-1:0] last_node;
    logic                 out_free;

    // Remainder unit link
    div_req_t             div_req;
    logic                 div_done;
    logic [DIV_DSR_W-1:0] div_rem;
    logic [CNT_W-1:0]     div_id;
    logic [LEN_W-1:0]     div_k;
    logic [DIV_DSR_W-1:0] div_dsr;

    // Clamp configuration and pick the current node
    always_comb
    begin
        if (active_reg == '0)
        begin
            n_wide = ACTIVE_W'(1);
        end
        else if (active_reg > ACTIVE_W'(NODE_CAP))
        begin
            n_wide = ACTIVE_W'(NODE_CAP);
        end
        else
        begin
            n_wide = active_reg;
        end
        n_eff = CNT_W'(n_wide);

        len_eff = (len_reg == '0) ? LEN_W'(1) : len_reg;

        if (max_att_reg == '0)
        begin
            lim_eff = ATT_CFG_W'(1);
        end
        else if (max_att_reg > ATT_CFG_W'(RANGE_LIMIT))
        begin
            lim_eff = ATT_CFG_W'(RANGE_LIMIT);
        end
        else
        begin
            lim_eff = max_att_reg;
        end

        idx_valid   = idx_reg < n_eff;
        cur_backoff = backoff_reg[idx_reg[IDX_W-1:0]];
        cur_attempt = attempt_reg[idx_reg[IDX_W-1:0]];
        cur_zero    = cur_backoff == '0;

        att_inc  = ATT_CFG_W'(cur_attempt) + ATT_CFG_W'(1);
        att_wrap = (att_inc >= lim_eff) ? '0 : att_inc[ATTEMPT_W-1:0];

        mod0    = (range_reg[0] == '0) ? RANGE_W'(1) : range_reg[0];
        mod_sel = (range_reg[att_wrap] == '0) ? RANGE_W'(1) : range_reg[att_wrap];

        busy_inc  = (busy_sum_reg == '1) ? busy_sum_reg : busy_sum_reg + 1'b1;
        last_wide = ACTIVE_W'(last_reg);
        last_node = last_wide[NODE_ID_W-1:0];
        out_free  = !out_valid_reg || out_ready;
    end

    // Build the remainder request: id + t + k mod the chosen range
    always_comb
    begin
        div_req.start = 1'b0;
        div_id        = idx_reg;
        div_k         = '0;
        div_dsr       = mod0;
        unique case (state_reg)
            S_INIT:
            begin
                div_req.start = idx_reg < CNT_W'(NODE_CAP);
            end
            S_SCAN:
            begin
                div_id        = last_reg;
                div_k         = len_eff;
                div_req.start = !idx_valid && (zeros_reg == COLL_W'(1));
            end
            S_COLL:
            begin
                div_k         = LEN_W'(1);
                div_dsr       = mod_sel;
                div_req.start = idx_valid && cur_zero;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
        div_req.dividend = DIV_DVD_W'(div_id) + DIV_DVD_W'(tick_reg) + DIV_DVD_W'(div_k);
        div_req.divisor  = div_dsr;
    end

    csma_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = restart ? S_INIT : S_TICK;
                end
            end
            S_INIT:
            begin
                state_next = (idx_reg < CNT_W'(NODE_CAP)) ? S_INIT_WAIT : S_TICK;
            end
            S_INIT_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_INIT;
                end
            end
            S_TICK:
            begin
                state_next = (busy_rem_reg != '0) ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                if (!idx_valid)
                begin
                    if (zeros_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (zeros_reg == COLL_W'(1))
                    begin
                        state_next = S_SEND_WAIT;
                    end
                    else
                    begin
                        state_next = S_COLL;
                    end
                end
            end
            S_SEND_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_COLL:
            begin
                if (!idx_valid)
                begin
                    state_next = S_DONE;
                end
                else if (cur_zero)
                begin
                    state_next = S_COLL_WAIT;
                end
            end
            S_COLL_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_COLL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= ACTIVE_RESET;
            len_reg      <= LEN_RESET;
            max_att_reg  <= ATT_RESET;
            range_reg[0] <= RANGE_W'(RANGE0_RESET);
            range_reg[1] <= RANGE1_RESET;
            range_reg[2] <= RANGE2_RESET;
            range_reg[3] <= RANGE3_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_NODES: active_reg   <= cfg_data[ACTIVE_W-1:0];
                REG_PACKET_LEN:   len_reg      <= cfg_data[LEN_W-1:0];
                REG_MAX_ATTEMPTS: max_att_reg  <= cfg_data[ATT_CFG_W-1:0];
                REG_RANGE_0:      range_reg[0] <= cfg_data[RANGE_W-1:0];
                REG_RANGE_1:      range_reg[1] <= cfg_data[RANGE_W-1:0];
                REG_RANGE_2:      range_reg[2] <= cfg_data[RANGE_W-1:0];
                REG_RANGE_3:      range_reg[3] <= cfg_data[RANGE_W-1:0];
                default:          active_reg   <= active_reg;
            endcase
        end
    end

    // Node state, channel state and sequencer counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            busy_rem_reg <= '0;
            busy_sum_reg <= '0;
            sender_reg   <= '0;
            idx_reg      <= '0;
            last_reg     <= '0;
            zeros_reg    <= '0;
            for (int i = 0; i < NODE_CAP; i++)
            begin
                backoff_reg[i] <= BACKOFF_W'(i % RANGE0_RESET);
                attempt_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    // accept a request; a restart clears the channel first
                    if (in_valid)
                    begin
                        idx_reg <= '0;
                        if (restart)
                        begin
                            tick_reg     <= '0;
                            busy_rem_reg <= '0;
                            busy_sum_reg <= '0;
                            sender_reg   <= '0;
                            for (int i = 0; i < NODE_CAP; i++)
                            begin
                                attempt_reg[i] <= '0;
                            end
                        end
                    end
                end
                S_INIT:
                begin
                    // hold the node index while its reload is requested
                    idx_reg <= idx_reg;
                end
                S_INIT_WAIT:
                begin
                    if (div_done)
                    begin
                        backoff_reg[idx_reg[IDX_W-1:0]] <= div_rem;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_TICK:
                begin
                    idx_reg   <= '0;
                    zeros_reg <= '0;
                    if (busy_rem_reg != '0)
                    begin
                        busy_rem_reg <= busy_rem_reg - 1'b1;
                        busy_sum_reg <= busy_inc;
                    end
                end
                S_SCAN:
                begin
                    if (idx_valid)
                    begin
                        if (cur_zero)
                        begin
                            zeros_reg <= zeros_reg + 1'b1;
                            last_reg  <= idx_reg;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (zeros_reg == '0)
                    begin
                        // nobody ready: count every active node down
                        for (int i = 0; i < NODE_CAP; i++)
                        begin
                            if (CNT_W'(i) < n_eff)
                            begin
                                backoff_reg[i] <= backoff_reg[i] - 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        idx_reg <= '0;
                    end
                end
                S_SEND_WAIT:
                begin
                    if (div_done)
                    begin
                        backoff_reg[last_reg[IDX_W-1:0]] <= div_rem;
                        attempt_reg[last_reg[IDX_W-1:0]] <= '0;
                        sender_reg   <= last_node;
                        busy_rem_reg <= len_eff - 1'b1;
                        busy_sum_reg <= busy_inc;
                    end
                end
                S_COLL:
                begin
                    if (idx_valid && !cur_zero)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_COLL_WAIT:
                begin
                    if (div_done)
                    begin
                        backoff_reg[idx_reg[IDX_W-1:0]] <= div_rem;
                        attempt_reg[idx_reg[IDX_W-1:0]] <= att_new_reg;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        tick_reg <= tick_reg + 1'b1;
                    end
                end
                default:
                begin
                    idx_reg <= '0;
                end
            endcase
        end
    end

    // Result fields and the new attempt index of a collider
    always_ff @(posedge clk)
    begin
        if (state_reg == S_COLL)
        begin
            att_new_reg <= att_wrap;
        end

        if (state_reg == S_TICK && busy_rem_reg != '0)
        begin
            res_event_reg <= EV_CONT;
            res_node_reg  <= sender_reg;
            res_coll_reg  <= '0;
        end
        else if (state_reg == S_SCAN && !idx_valid && zeros_reg == '0)
        begin
            res_event_reg <= EV_IDLE;
            res_node_reg  <= '0;
            res_coll_reg  <= '0;
        end
        else if (state_reg == S_SEND_WAIT && div_done)
        begin
            res_event_reg <= EV_START;
            res_node_reg  <= last_node;
            res_coll_reg  <= '0;
        end
        else if (state_reg == S_COLL && !idx_valid)
        begin
            res_event_reg <= EV_COLL;
            res_node_reg  <= '0;
            res_coll_reg  <= zeros_reg;
        end

        if (state_reg == S_DONE && out_free)
        begin
            out_event_reg <= res_event_reg;
            out_node_reg  <= res_node_reg;
            out_coll_reg  <= res_coll_reg;
            out_busy_reg  <= busy_sum_reg;
            out_tick_reg  <= tick_reg;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign in_ready   = state_reg == S_IDLE;
    assign out_valid  = out_valid_reg;
    assign event_res  = out_event_reg;
    assign node_id    = out_node_reg;
    assign colliders  = out_coll_reg;
    assign busy_total = out_busy_reg;
    assign tick_index = out_tick_reg;

    // A packet in flight has already been counted as busy time
    a_busy_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_rem_reg != '0) |-> (busy_sum_reg != '0))
        else $error("packet in flight without busy time");

    // Zero count never runs ahead of the scan position
    a_zeros_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (zeros_reg <= COLL_W'(idx_reg)))
        else $error("zero count exceeds scanned nodes");

    // An accepted request always starts work
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted request left the sequencer idle");

endmodule

FILE: src/csma_div.sv
// ============================================================================
// csma_div - shared restoring remainder unit
// Takes a 33-bit dividend and a non-zero 16-bit divisor, retires one dividend
// bit per cycle and pulses done with the remainder after 33 steps.
// ============================================================================
module csma_div
    import csma_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    output logic                 done,
    output logic [DIV_DSR_W-1:0] remainder
);

    localparam int STEP_W = $clog2(DIV_DVD_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIV_DVD_W-1:0] dvd_reg;
    logic [DIV_DSR_W-1:0] dsr_reg;
    logic [DIV_DSR_W-1:0] rem_reg;

    logic [DIV_DSR_W:0]   trial;
    logic [DIV_DSR_W:0]   diff;
    logic [DIV_DSR_W-1:0] rem_step;

    // One restoring step: bring in the next bit, subtract when it fits
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIV_DVD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_step = (trial >= {1'b0, dsr_reg}) ? diff[DIV_DSR_W-1:0]
                                               : trial[DIV_DSR_W-1:0];
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(DIV_DVD_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operand and partial remainder
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_DVD_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    // Partial remainder stays below the divisor throughout
    a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dsr_reg))
        else $error("partial remainder not below divisor");

    // Last step raises done in the next cycle
    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start && step_reg == STEP_W'(1)) |=> done_reg)
        else $error("done missing after last step");

    // No restart while a remainder is in progress
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("remainder unit started while busy");

endmodule

FILE: sim/csma_backoff_channel_arbiter_tb.sv
// ----------------------------------------------------------------------------
// csma_backoff_channel_arbiter_tb - self-checking bench for the backoff arbiter
// Offers tick requests through a paced driver and collects results through a
// stalling monitor. A behavioural predictor mirrors the node backoffs, attempt
// indexes, busy accounting and register file, and every result is compared
// field by field with the oldest prediction. Directed ticks cover register
// extremes, collisions, sends and restarts; random phases follow.
// ----------------------------------------------------------------------------
module csma_backoff_channel_arbiter_tb import csma_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_COUNT = NODES_DEFAULT;

    typedef struct packed {
        event_t                ev;
        logic [NODE_ID_W-1:0]  node;
        logic [COLL_W-1:0]     coll;
        logic [BUSY_W-1:0]     busy;
        logic [TICK_W-1:0]     tick;
    } tick_result_t;

    // clock, reset and block ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  restart   = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            event_res;
    logic [NODE_ID_W-1:0]  node_id;
    logic [COLL_W-1:0]     colliders;
    logic [BUSY_W-1:0]     busy_total;
    logic [TICK_W-1:0]     tick_index;

    // pending requests, predicted results and pacing controls
    logic         tick_queue[$];
    tick_result_t results_due[$];
    int           fail_count = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;
    logic         stall_arm  = 1'b0;
    int unsigned  stall_left = 0;
    int unsigned  tx_gap;
    int unsigned  rx_gap;

    // predictor copy of the register file
    logic [ACTIVE_W-1:0]  cfg_active = ACTIVE_RESET;
    logic [LEN_W-1:0]     cfg_len    = LEN_RESET;
    logic [ATT_CFG_W-1:0] cfg_att    = ATT_RESET;
    logic [RANGE_W-1:0]   range_mirror[0:3] = '{RANGE_W'(RANGE0_RESET), RANGE1_RESET,
                                                RANGE2_RESET, RANGE3_RESET};

    // predictor copy of the channel state
    logic [BACKOFF_W-1:0] backoff[0:NODE_COUNT-1];
    logic [ATTEMPT_W-1:0] attempt[0:NODE_COUNT-1];
    logic [TICK_W-1:0]    tick_now;
    logic [LEN_W-1:0]     busy_left;
    logic [BUSY_W-1:0]    busy_acc;
    logic [NODE_ID_W-1:0] sender;

    csma_backoff_channel_arbiter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .node_id    (node_id),
        .colliders  (colliders),
        .busy_total (busy_total),
        .tick_index (tick_index)
    );

    always #6 clk = ~clk;

    // Backoff modulus for an attempt index; a zero range acts as one
    function automatic logic [RANGE_W-1:0] modulus_of(input logic [ATTEMPT_W-1:0] a);
        return (range_mirror[a] == '0) ? RANGE_W'(1) : range_mirror[a];
    endfunction

    // Reload every node and clear the time and busy accounting
    function automatic void reload_nodes();
        logic [RANGE_W-1:0] m;
        m = modulus_of(2'd0);
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            backoff[i] = BACKOFF_W'(i % m);
            attempt[i] = '0;
        end
        tick_now  = '0;
        busy_left = '0;
        busy_acc  = '0;
        sender    = '0;
    endfunction

    // Advance the channel by one tick and return the result it reports
    function automatic tick_result_t channel_tick(input logic restart_req);
        tick_result_t r;
        int unsigned  n;
        int unsigned  zeros;
        int unsigned  last;
        int unsigned  lim;
        int unsigned  a;
        logic [63:0]  sum;
        logic [TICK_W-1:0] t;
        logic [LEN_W-1:0]  len;
        n = (cfg_active == '0) ? 1 : ((cfg_active > NODE_COUNT) ? NODE_COUNT : cfg_active);
        if (restart_req)
            reload_nodes();
        t      = tick_now;
        r.ev   = EV_IDLE;
        r.node = '0;
        r.coll = '0;
        if (busy_left != '0)
        begin
            busy_left--;
            if (busy_acc != '1)
                busy_acc++;
            r.ev   = EV_CONT;
            r.node = sender;
        end
        else
        begin
            zeros = 0;
            last  = 0;
            for (int i = 0; i < n; i++)
            begin
                if (backoff[i] == '0)
                begin
                    zeros++;
                    last = i;
                end
            end
            if (zeros == 0)
            begin
                for (int i = 0; i < n; i++)
                    backoff[i]--;
            end
            else if (zeros == 1)
            begin
                len           = (cfg_len == '0) ? LEN_W'(1) : cfg_len;
                sum           = 64'(last) + 64'(t) + 64'(len);
                attempt[last] = '0;
                backoff[last] = BACKOFF_W'(sum % modulus_of(2'd0));
                sender        = NODE_ID_W'(last);
                busy_left     = len - 1'b1;
                if (busy_acc != '1)
                    busy_acc++;
                r.ev   = EV_START;
                r.node = sender;
            end
            else
            begin
                lim = (cfg_att == '0) ? 1 : ((cfg_att > RANGE_LIMIT) ? RANGE_LIMIT : cfg_att);
                for (int i = 0; i < n; i++)
                begin
                    if (backoff[i] == '0)
                    begin
                        a = attempt[i] + 1;
                        if (a >= lim)
                            a = 0;
                        sum        = 64'(i) + 64'(t) + 64'd1;
                        attempt[i] = ATTEMPT_W'(a);
                        backoff[i] = BACKOFF_W'(sum % modulus_of(ATTEMPT_W'(a)));
                    end
                end
                r.ev   = EV_COLL;
                r.coll = (zeros > 15) ? COLL_W'(15) : COLL_W'(zeros);
            end
        end
        r.busy   = busy_acc;
        r.tick   = t;
        tick_now = t + 1'b1;
        return r;
    endfunction

    // Write one register and mirror it; only called while the block is idle
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_ACTIVE_NODES: cfg_active = value[ACTIVE_W-1:0];
            REG_PACKET_LEN:   cfg_len    = value[LEN_W-1:0];
            REG_MAX_ATTEMPTS: cfg_att    = value[ATT_CFG_W-1:0];
            REG_RANGE_0, REG_RANGE_1, REG_RANGE_2, REG_RANGE_3:
                range_mirror[idx - REG_RANGE_0] = value[RANGE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Append one request to the pending queue
    task automatic queue_tick(input logic restart_req);
        tick_queue = {tick_queue, restart_req};
    endtask

    // Hold until every request is taken and every result is back, then settle
    task automatic wait_drained(input int settle);
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || in_valid || results_due.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Driver: offer queued requests, with a random gap after each one while gaps are on
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
            tx_gap = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                tx_gap = tx_idle_on ? $urandom_range(0, 9) : 0;
            if (tx_gap != 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (tick_queue.size() != 0)
            begin
                in_valid <= 1'b1;
                restart  <= tick_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Predict the result of each accepted request
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            results_due = {results_due, channel_tick(restart)};
    end

    // Count down a long receiver hold-off once armed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_left <= 0;
        else if (stall_arm)
            stall_left <= 400;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    // Monitor: check each result against the oldest prediction, pace ready
    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: result with none expected: event %0d node %0d tick %0d",
                             $time, event_res, node_id, tick_index);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (event_res !== want.ev)
                    begin
                        $display("%0t: event_res expected %0d, got %0d",
                                 $time, want.ev, event_res);
                        fail_count++;
                    end
                    if (node_id !== want.node)
                    begin
                        $display("%0t: node_id expected %0d, got %0d",
                                 $time, want.node, node_id);
                        fail_count++;
                    end
                    if (colliders !== want.coll)
                    begin
                        $display("%0t: colliders expected %0d, got %0d",
                                 $time, want.coll, colliders);
                        fail_count++;
                    end
                    if (busy_total !== want.busy)
                    begin
                        $display("%0t: busy_total expected %0d, got %0d",
                                 $time, want.busy, busy_total);
                        fail_count++;
                    end
                    if (tick_index !== want.tick)
                    begin
                        $display("%0t: tick_index expected %0d, got %0d",
                                 $time, want.tick, tick_index);
                        fail_count++;
                    end
                end
                rx_gap = rx_idle_on ? $urandom_range(0, 9) : 0;
            end
            else if (rx_gap != 0)
                rx_gap--;
            out_ready <= (rx_gap == 0) && (stall_left == 0);
        end
    end

    // Stimulus: directed phases, then random phases with fresh settings
    initial
    begin
        logic [CFG_DATA_W-1:0] pick;
        reload_nodes();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // all nodes start at zero: repeated full collisions, zero range acts as one
        write_reg(REG_ACTIVE_NODES, 16'd8);
        write_reg(REG_PACKET_LEN,   16'd2);
        write_reg(REG_MAX_ATTEMPTS, 16'd7);
        write_reg(REG_RANGE_0,      16'd1);
        write_reg(REG_RANGE_1,      16'd0);
        write_reg(REG_RANGE_2,      16'd3);
        write_reg(REG_RANGE_3,      16'hFFFF);
        queue_tick(1'b1);
        repeat (7) queue_tick(1'b0);
        wait_drained(8);

        // single node, zero packet length, zero max attempts, widest range
        write_reg(REG_ACTIVE_NODES, 16'd1);
        write_reg(REG_PACKET_LEN,   16'd0);
        write_reg(REG_MAX_ATTEMPTS, 16'd0);
        write_reg(REG_RANGE_0,      16'hFFFF);
        queue_tick(1'b1);
        repeat (6) queue_tick(1'b0);
        wait_drained(8);

        // too many nodes, longest packet length, then a second restart in mid-run
        write_reg(REG_ACTIVE_NODES, 16'd15);
        write_reg(REG_PACKET_LEN,   16'hFFFF);
        write_reg(REG_MAX_ATTEMPTS, 16'd1);
        write_reg(REG_RANGE_0,      16'd2);
        queue_tick(1'b1);
        repeat (5) queue_tick(1'b0);
        queue_tick(1'b1);
        repeat (2) queue_tick(1'b0);
        wait_drained(8);

        for (int p = 0; p < 10; p++)
        begin
            tx_idle_on = (p % 3 != 1) && (p != 3) && (p != 7);
            rx_idle_on = (p % 3 != 2);
            write_reg(REG_ACTIVE_NODES, 16'($urandom_range(0, 65535)));
            case ($urandom_range(0, 9))
                0:       pick = 16'hFFFF;
                1:       pick = 16'($urandom_range(0, 65535));
                default: pick = 16'($urandom_range(0, 12));
            endcase
            write_reg(REG_PACKET_LEN, pick);
            write_reg(REG_MAX_ATTEMPTS, 16'($urandom_range(0, 65535)));
            for (int j = 0; j < 4; j++)
            begin
                case ($urandom_range(0, 7))
                    0:       pick = 16'hFFFF;
                    1:       pick = 16'($urandom_range(0, 65535));
                    2:       pick = 16'd0;
                    default: pick = 16'($urandom_range(1, 20));
                endcase
                write_reg(cfg_reg_t'(REG_RANGE_0 + j), pick);
            end
            // open each phase with a restart, then mostly plain ticks
            for (int k = 0; k < 123; k++)
                queue_tick(k == 0 || $urandom_range(0, 39) == 0);
            // hold the receiver off while the driver keeps offering
            if (p == 3 || p == 7)
            begin
                @(posedge clk);
                stall_arm <= 1'b1;
                @(posedge clk);
                stall_arm <= 1'b0;
            end
            wait_drained(8);
        end

        wait_drained(64);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: end a hung run
    initial
    begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/csma_pkg.sv
src/csma_div.sv
src/csma_backoff_channel_arbiter.sv
sim/csma_backoff_channel_arbiter_tb.sv
